### hw/rtl/rqa_pkg.sv
// ============================================================================
// rqa_pkg
// Types and codes shared by the ready queue with aging and its checker.
// ============================================================================
package rqa_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_TAIL = 3'd0,
        OP_PUSH_HEAD = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_INSERT    = 3'd3,
        OP_AGE       = 3'd4,
        OP_PEEK      = 3'd5,
        OP_POP_SHORT = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_CLOSE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] score;
        logic [15:0] run_time;
    } t_entry;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  entry_tag;
        logic [15:0] length_score;
        logic [15:0] run_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        out_valid;
        logic [7:0]  out_tag;
        logic [15:0] out_score;
        logic [15:0] out_time;
        logic [4:0]  occupancy;
    } t_out_item;

endpackage

### hw/rtl/ready_queue_with_aging.sv
// ============================================================================
// ready_queue_with_aging
// Ordered ready queue kept in one memory, slot 0 is the head.
// ============================================================================
// Operation: push tail goes through the shift and write states to the result
//   register; push head, sorted insert, age and pops walk the memory one entry
//   per cycle (push head shifts; insert scans, then shifts; pops scan, then close the gap; age scans).
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: synchronous active low; the queue is empty, memory is not cleared.
module ready_queue_with_aging #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rqa_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rqa_pkg::t_out_item  o_out_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rqa_pkg::t_state    r_state, n_state;
    logic [2:0]         r_op, n_op;
    rqa_pkg::t_entry    r_new, n_new;
    rqa_pkg::t_entry    r_best, n_best;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_lim, n_lim;
    logic [CW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_pidx, n_pidx;
    logic               r_pend, n_pend;
    logic               r_hit, n_hit;
    logic [1:0]         r_status, n_status;
    logic               r_ovld, n_ovld;
    rqa_pkg::t_out_item r_out, n_out;

    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    rqa_pkg::t_entry    wr_data, rd_data;

    logic               in_acc, out_load;
    logic               is_ins, is_age, is_peek;
    logic               ins_hit, take_d, scan_last, scan_stop;
    logic [CW-1:0]      idx_m1, idx_p1, pidx_p1, pidx_m1, pos_fin, lim_m1;
    logic               full, empty;
    logic [CW+4:0]      occ_w;

    rqa_store #(.DEPTH(DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign in_acc    = i_in_valid && (r_state == rqa_pkg::S_IDLE);
    assign out_load  = (r_state == rqa_pkg::S_DONE) && (!r_ovld || !i_out_stall);
    assign is_ins    = (r_op == rqa_pkg::OP_INSERT);
    assign is_age    = (r_op == rqa_pkg::OP_AGE);
    assign is_peek   = (r_op == rqa_pkg::OP_PEEK);
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign idx_m1    = r_idx - CW'(1);
    assign idx_p1    = r_idx + CW'(1);
    assign pidx_p1   = r_pidx + CW'(1);
    assign pidx_m1   = r_pidx - CW'(1);
    assign lim_m1    = r_lim - CW'(1);
    assign occ_w     = {5'd0, r_count};

    // new entry goes before the head on a tie or lower; before later entries only on strictly greater
    assign ins_hit   = r_pend && ((r_pidx == '0) ? (r_new.score <= rd_data.score)
                                                 : (rd_data.score > r_new.score));
    assign take_d    = r_pend && ((r_pidx == '0) || (rd_data.run_time < r_best.run_time));
    assign scan_last = r_pend && (r_pidx == lim_m1);
    assign scan_stop = is_ins ? (ins_hit || scan_last) : scan_last;
    assign pos_fin   = take_d ? r_pidx : r_pos;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rqa_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_item.operation)
                        rqa_pkg::OP_PUSH_TAIL, rqa_pkg::OP_PUSH_HEAD: begin
                            n_state = full ? rqa_pkg::S_DONE : rqa_pkg::S_SHIFT;
                        end
                        rqa_pkg::OP_INSERT: begin
                            if (full) begin
                                n_state = rqa_pkg::S_DONE;
                            end else if (empty) begin
                                n_state = rqa_pkg::S_SHIFT;
                            end else begin
                                n_state = rqa_pkg::S_SCAN;
                            end
                        end
                        rqa_pkg::OP_POP_HEAD, rqa_pkg::OP_PEEK, rqa_pkg::OP_POP_SHORT,
                        rqa_pkg::OP_AGE: begin
                            n_state = empty ? rqa_pkg::S_DONE : rqa_pkg::S_SCAN;
                        end
                        default: n_state = rqa_pkg::S_DONE;
                    endcase
                end
            end
            rqa_pkg::S_SCAN: begin
                if (scan_stop) begin
                    if (is_ins) begin
                        n_state = rqa_pkg::S_SHIFT;
                    end else if (is_age || is_peek) begin
                        n_state = rqa_pkg::S_DONE;
                    end else begin
                        n_state = rqa_pkg::S_CLOSE;
                    end
                end
            end
            rqa_pkg::S_SHIFT: begin
                if ((r_idx == r_pos) && !r_pend) begin
                    n_state = rqa_pkg::S_WRITE;
                end
            end
            rqa_pkg::S_WRITE: n_state = rqa_pkg::S_DONE;
            rqa_pkg::S_CLOSE: begin
                if (!(r_idx < r_count) && !r_pend) begin
                    n_state = rqa_pkg::S_DONE;
                end
            end
            rqa_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = rqa_pkg::S_IDLE;
                end
            end
            default: n_state = rqa_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op     = r_op;
        n_new    = r_new;
        n_best   = r_best;
        n_count  = r_count;
        n_idx    = r_idx;
        n_lim    = r_lim;
        n_pos    = r_pos;
        n_pidx   = r_idx;
        n_pend   = 1'b0;
        n_hit    = r_hit;
        n_status = r_status;
        n_ovld   = r_ovld && i_out_stall;
        n_out    = r_out;
        rd_en    = 1'b0;
        rd_addr  = r_idx[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_pos[AW-1:0];
        wr_data  = rd_data;
        unique case (r_state)
            rqa_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op     = i_in_item.operation;
                    n_new    = '{tag: i_in_item.entry_tag, score: i_in_item.length_score,
                                 run_time: i_in_item.run_time};
                    n_best   = '0;
                    n_hit    = 1'b0;
                    n_status = rqa_pkg::ST_DONE;
                    n_idx    = '0;
                    n_pos    = '0;
                    n_lim    = r_count;
                    unique case (i_in_item.operation)
                        rqa_pkg::OP_PUSH_TAIL: begin
                            n_pos = r_count;
                            n_idx = r_count;
                        end
                        rqa_pkg::OP_PUSH_HEAD: n_idx = r_count;
                        rqa_pkg::OP_INSERT:    n_idx = empty ? r_count : '0;
                        rqa_pkg::OP_POP_HEAD, rqa_pkg::OP_PEEK: n_lim = CW'(1);
                        default: ;
                    endcase
                    if (full && (i_in_item.operation == rqa_pkg::OP_PUSH_TAIL ||
                                 i_in_item.operation == rqa_pkg::OP_PUSH_HEAD ||
                                 i_in_item.operation == rqa_pkg::OP_INSERT)) begin
                        n_status = rqa_pkg::ST_FULL;
                    end
                    if (empty && (i_in_item.operation == rqa_pkg::OP_POP_HEAD ||
                                  i_in_item.operation == rqa_pkg::OP_PEEK ||
                                  i_in_item.operation == rqa_pkg::OP_POP_SHORT)) begin
                        n_status = rqa_pkg::ST_EMPTY;
                    end
                end
            end
            rqa_pkg::S_SCAN: begin
                rd_en = (r_idx < r_lim) && !scan_stop;
                if (rd_en) begin
                    n_idx  = idx_p1;
                    n_pend = 1'b1;
                end
                if (r_pend && is_age) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pidx[AW-1:0];
                    wr_data = rd_data;
                    if (rd_data.score != '0) begin
                        wr_data.score = rd_data.score - 16'd1;
                    end
                end
                if (!is_ins && !is_age && take_d) begin
                    n_best = rd_data;
                    n_pos  = r_pidx;
                end
                if (scan_stop) begin
                    if (is_ins) begin
                        n_idx = r_count;
                        n_pos = ins_hit ? r_pidx : r_count;
                    end else if (!is_age) begin
                        n_hit = 1'b1;
                        n_idx = pos_fin + CW'(1);
                    end
                end
            end
            rqa_pkg::S_SHIFT: begin
                // entries move up one slot, tail first
                rd_en   = (r_idx > r_pos);
                rd_addr = idx_m1[AW-1:0];
                if (rd_en) begin
                    n_idx  = idx_m1;
                    n_pend = 1'b1;
                    n_pidx = idx_m1;
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = pidx_p1[AW-1:0];
                end
            end
            rqa_pkg::S_WRITE: begin
                wr_en   = 1'b1;
                wr_data = r_new;
                n_count = r_count + CW'(1);
            end
            rqa_pkg::S_CLOSE: begin
                // entries after the gap move down one slot
                rd_en = (r_idx < r_count);
                if (rd_en) begin
                    n_idx  = idx_p1;
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = pidx_m1[AW-1:0];
                end
                if (!rd_en && !r_pend) begin
                    n_count = r_count - CW'(1);
                end
            end
            rqa_pkg::S_DONE: begin
                if (out_load) begin
                    n_ovld = 1'b1;
                    n_out  = '{status: r_status, out_valid: r_hit, out_tag: r_best.tag,
                              out_score: r_best.score, out_time: r_best.run_time,
                              occupancy: occ_w[4:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rqa_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_new    <= n_new;
        r_best   <= n_best;
        r_idx    <= n_idx;
        r_lim    <= n_lim;
        r_pos    <= n_pos;
        r_pidx   <= n_pidx;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != rqa_pkg::S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_item  = r_out;

endmodule

### hw/rtl/rqa_store.sv
// ============================================================================
// rqa_store
// Entry memory: one write port, one read port with registered read data.
// ============================================================================
module rqa_store #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output rqa_pkg::t_entry          o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  rqa_pkg::t_entry          i_wr_data
);

    rqa_pkg::t_entry mem [DEPTH];
    rqa_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/rqa_checker.sv
// ============================================================================
// rqa_checker
// Port-level checks on the ready queue results.
// ============================================================================
module rqa_checker #(
    parameter int DEPTH = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rqa_pkg::t_out_item o_out_item
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled item changed");

    a_entry_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.out_valid |-> o_out_item.status == rqa_pkg::ST_DONE)
        else $error("entry returned with bad status");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == rqa_pkg::ST_EMPTY
        |-> !o_out_item.out_valid && o_out_item.occupancy == '0)
        else $error("empty status on non-empty queue");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == rqa_pkg::ST_FULL
        |-> o_out_item.occupancy == 5'(DEPTH))
        else $error("full status on non-full queue");

endmodule

bind ready_queue_with_aging rqa_checker #(.DEPTH(DEPTH)) u_rqa_checker (.*);

### tb/sv/ready_queue_with_aging_tb.sv
// ============================================================================
// ready_queue_with_aging_tb
// Drives push, insert, age, peek and pop items into the ready queue, keeps a
// queue model of its own and checks every result field by field.
// ============================================================================
module ready_queue_with_aging_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int N_RANDOM = 1400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    rqa_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    rqa_pkg::t_out_item o_out_item;

    ready_queue_with_aging #(.DEPTH(DEPTH)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_item(o_out_item)
    );

    always #4 i_clk = ~i_clk;

    // queue model, slot 0 is the head
    rqa_pkg::t_entry    q_slots[$];
    rqa_pkg::t_out_item expected_results[$];
    int        n_errors = 0;
    int        n_results = 0;
    int        n_sent = 0;
    int        n_full = 0;
    int        n_empty = 0;
    bit        idle_on = 1'b1;
    bit        all_sent = 1'b0;

    function automatic rqa_pkg::t_out_item queue_step(rqa_pkg::t_in_item it);
        rqa_pkg::t_out_item r;
        rqa_pkg::t_entry    e;
        int                 pos;
        r = '0;
        e.tag = it.entry_tag;
        e.score = it.length_score;
        e.run_time = it.run_time;
        case (it.operation)
            rqa_pkg::OP_PUSH_TAIL, rqa_pkg::OP_PUSH_HEAD, rqa_pkg::OP_INSERT: begin
                if (q_slots.size() >= DEPTH) begin
                    r.status = rqa_pkg::ST_FULL;
                end else if (it.operation == rqa_pkg::OP_PUSH_TAIL) begin
                    q_slots.push_back(e);
                end else if (it.operation == rqa_pkg::OP_PUSH_HEAD || q_slots.size() == 0
                             || it.length_score <= q_slots[0].score) begin
                    q_slots.push_front(e);
                end else begin
                    pos = 1;
                    while (pos < q_slots.size() && q_slots[pos].score <= it.length_score)
                        pos++;
                    q_slots.insert(pos, e);
                end
            end
            rqa_pkg::OP_POP_HEAD, rqa_pkg::OP_PEEK, rqa_pkg::OP_POP_SHORT: begin
                if (q_slots.size() == 0) begin
                    r.status = rqa_pkg::ST_EMPTY;
                end else begin
                    pos = 0;
                    if (it.operation == rqa_pkg::OP_POP_SHORT)
                        for (int i = 1; i < q_slots.size(); i++)
                            if (q_slots[i].run_time < q_slots[pos].run_time) pos = i;
                    r.out_valid = 1'b1;
                    r.out_tag = q_slots[pos].tag;
                    r.out_score = q_slots[pos].score;
                    r.out_time = q_slots[pos].run_time;
                    if (it.operation != rqa_pkg::OP_PEEK) q_slots.delete(pos);
                end
            end
            rqa_pkg::OP_AGE: begin
                foreach (q_slots[i])
                    if (q_slots[i].score != 0) q_slots[i].score--;
            end
            default: ;
        endcase
        r.occupancy = 5'(q_slots.size());
        return r;
    endfunction

    // same prediction on a copy of the queue, used to cross-check typed rows
    function automatic rqa_pkg::t_out_item queue_step_peek(rqa_pkg::t_in_item it);
        rqa_pkg::t_entry    saved[$];
        rqa_pkg::t_out_item r;
        saved = q_slots;
        r = queue_step(it);
        q_slots = saved;
        return r;
    endfunction

    task automatic send_item(rqa_pkg::t_in_item it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(queue_step(it));
        n_sent++;
    endtask

    function automatic rqa_pkg::t_in_item make_item(rqa_pkg::t_op op, int tag, int score,
                                                    int tm);
        rqa_pkg::t_in_item it;
        it.operation = op;
        it.entry_tag = 8'(tag);
        it.length_score = 16'(score);
        it.run_time = 16'(tm);
        return it;
    endfunction

    // result side: stall bursts and checks
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result %p", o_out_item);
                    n_errors++;
                end else begin
                    rqa_pkg::t_out_item x;
                    x = expected_results.pop_front();
                    if (x.status == rqa_pkg::ST_FULL) n_full++;
                    if (x.status == rqa_pkg::ST_EMPTY) n_empty++;
                    if (o_out_item.status !== x.status) begin
                        $error("status: expected %0d, got %0d", x.status, o_out_item.status);
                        n_errors++;
                    end
                    if (o_out_item.out_valid !== x.out_valid) begin
                        $error("out_valid: expected %0d, got %0d",
                               x.out_valid, o_out_item.out_valid);
                        n_errors++;
                    end
                    if (o_out_item.out_tag !== x.out_tag) begin
                        $error("out_tag: expected %0d, got %0d", x.out_tag, o_out_item.out_tag);
                        n_errors++;
                    end
                    if (o_out_item.out_score !== x.out_score) begin
                        $error("out_score: expected %0d, got %0d",
                               x.out_score, o_out_item.out_score);
                        n_errors++;
                    end
                    if (o_out_item.out_time !== x.out_time) begin
                        $error("out_time: expected %0d, got %0d",
                               x.out_time, o_out_item.out_time);
                        n_errors++;
                    end
                    if (o_out_item.occupancy !== x.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               x.occupancy, o_out_item.occupancy);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin : stall_gen
        int burst;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 13);
                i_out_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    // directed rows: item, expected result where obvious, check flag
    typedef struct {
        rqa_pkg::t_in_item  item;
        bit                 typed;
        rqa_pkg::t_out_item res;
    } t_row;

    t_row directed_rows[$];

    task automatic add_row(rqa_pkg::t_in_item it, bit typed, rqa_pkg::t_out_item r);
        t_row row;
        row.item = it;
        row.typed = typed;
        row.res = r;
        directed_rows.push_back(row);
    endtask

    function automatic rqa_pkg::t_out_item res_of(rqa_pkg::t_status st, int occ);
        rqa_pkg::t_out_item r;
        r = '0;
        r.status = st;
        r.occupancy = 5'(occ);
        return r;
    endfunction

    initial begin : stimulus
        rqa_pkg::t_in_item  it;
        rqa_pkg::t_out_item pred;
        int                 kind;
        int                 base;
        // empty-queue cases, then extremes and every operation
        add_row(make_item(rqa_pkg::OP_POP_HEAD, 0, 0, 0), 1, res_of(rqa_pkg::ST_EMPTY, 0));
        add_row(make_item(rqa_pkg::OP_PEEK, 0, 0, 0), 1, res_of(rqa_pkg::ST_EMPTY, 0));
        add_row(make_item(rqa_pkg::OP_POP_SHORT, 0, 0, 0), 1, res_of(rqa_pkg::ST_EMPTY, 0));
        add_row(make_item(rqa_pkg::OP_AGE, 0, 0, 0), 1, res_of(rqa_pkg::ST_DONE, 0));
        add_row(make_item(rqa_pkg::t_op'(3'd7), 255, 65535, 65535), 1,
                res_of(rqa_pkg::ST_DONE, 0));
        add_row(make_item(rqa_pkg::OP_INSERT, 8'hff, 16'hffff, 16'hffff), 1,
                res_of(rqa_pkg::ST_DONE, 1));
        add_row(make_item(rqa_pkg::OP_INSERT, 1, 16'hffff, 5), 0, '0);
        add_row(make_item(rqa_pkg::OP_INSERT, 2, 0, 0), 0, '0);
        add_row(make_item(rqa_pkg::OP_INSERT, 3, 100, 7), 0, '0);
        add_row(make_item(rqa_pkg::OP_INSERT, 4, 100, 0), 0, '0);
        add_row(make_item(rqa_pkg::OP_PUSH_HEAD, 5, 1, 65535), 0, '0);
        add_row(make_item(rqa_pkg::OP_PUSH_TAIL, 6, 0, 3), 0, '0);
        add_row(make_item(rqa_pkg::OP_AGE, 0, 0, 0), 0, '0);
        add_row(make_item(rqa_pkg::OP_PEEK, 0, 0, 0), 0, '0);
        add_row(make_item(rqa_pkg::OP_POP_SHORT, 0, 0, 0), 0, '0);
        for (int i = 0; i < 10; i++)
            add_row(make_item(rqa_pkg::OP_PUSH_TAIL, 16 + i, i * 7, 1000 - i), 0, '0);
        add_row(make_item(rqa_pkg::OP_PUSH_HEAD, 9, 9, 9), 1, res_of(rqa_pkg::ST_FULL, 16));
        add_row(make_item(rqa_pkg::OP_INSERT, 9, 9, 9), 1, res_of(rqa_pkg::ST_FULL, 16));
        add_row(make_item(rqa_pkg::OP_POP_HEAD, 0, 0, 0), 0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].typed) begin
                pred = queue_step_peek(directed_rows[r].item);
                if (pred !== directed_rows[r].res) begin
                    $error("directed row %0d: table %p, model %p", r,
                           directed_rows[r].res, pred);
                    n_errors++;
                end
            end
            send_item(directed_rows[r].item);
        end

        // random: mostly fill/drain phases, extremes often, some noise
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 150) idle_on = 1'b0;
            kind = $urandom_range(0, 99);
            base = ((n / 60) % 2 == 0) ? 70 : 30; // alternate filling and draining
            it.entry_tag = 8'($urandom);
            it.length_score = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                            : 16'($urandom_range(0, 12));
            if ($urandom_range(0, 15) == 0) it.length_score = 16'hffff;
            it.run_time = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                        : 16'($urandom_range(0, 10));
            if (kind < base)
                it.operation = rqa_pkg::t_op'($urandom_range(0, 1) ? rqa_pkg::OP_INSERT
                               : ($urandom_range(0, 1) ? rqa_pkg::OP_PUSH_TAIL
                                                       : rqa_pkg::OP_PUSH_HEAD));
            else if (kind < 96)
                it.operation = rqa_pkg::t_op'($urandom_range(0, 1) ? rqa_pkg::OP_POP_SHORT
                               : ($urandom_range(0, 1) ? rqa_pkg::OP_POP_HEAD
                               : ($urandom_range(0, 1) ? rqa_pkg::OP_PEEK : rqa_pkg::OP_AGE)));
            else
                it.operation = 3'($urandom_range(0, 7));
            send_item(it);
        end
        i_in_valid <= 1'b0;
        all_sent = 1'b1;
    end

    initial begin : finish_ctl
        wait (all_sent);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4 * DEPTH + 20) @(posedge i_clk);
        $display("%0d items sent, %0d results checked; %0d full drops, %0d empty pops/peeks",
                 n_sent, n_results, n_full, n_empty);
        if (n_errors == 0) begin
            $display("ready_queue_with_aging test passed");
        end else begin
            $display("ready_queue_with_aging test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("ready_queue_with_aging test failed");
        $finish;
    end
endmodule
